// ----- rtl/core/spwc_pkg.sv -----
// Package for the sampled page write counter.
// Holds the transaction payload types, status, mode, region and register codes, reset values and fixed widths.
// No dependencies.
package spwc_pkg;

    localparam int ADDR_W     = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = 52;
    localparam int CNT_W      = 32;
    localparam int SCOUNT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 52;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0]    THRESHOLD_RST   = 32'd16;
    localparam logic [SCOUNT_W-1:0] STACK_COUNT_RST = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_EN    = 3'd4;

    // Input modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_ARMED   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Region codes
    localparam logic REGION_DATA  = 1'b0;
    localparam logic REGION_STACK = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] write_addr;
    } t_in_item;

    typedef struct packed {
        logic              rebalance;
        logic [PAGE_W-1:0] page_number;
        logic              region;
        logic [1:0]        status;
    } t_out_item;

endpackage

// ----- rtl/core/spwc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/spwc_decode.sv -----
// Page decode: region choice, stack mirror fold, range check and counter index.
// Depends on spwc_pkg.
module spwc_decode import spwc_pkg::*; #(
    parameter int DATA_PAGES      = 1024,
    parameter int STACK_PAGES_MAX = 64,
    localparam int DIDX_W = (DATA_PAGES > 1) ? $clog2(DATA_PAGES) : 1,
    localparam int SIDX_W = (STACK_PAGES_MAX > 1) ? $clog2(STACK_PAGES_MAX) : 1
) (
    input  t_in_item            i_item,
    input  logic                i_armed,
    input  logic [PAGE_W-1:0]   i_data_base,
    input  logic [PAGE_W-1:0]   i_stack_base,
    input  logic [SCOUNT_W-1:0] i_stack_count,
    input  logic                i_stack_en,
    output t_out_item           o_item,
    output logic [DIDX_W-1:0]   o_didx,
    output logic [SIDX_W-1:0]   o_sidx
);

    localparam int NW = ($clog2(STACK_PAGES_MAX + 1) > SCOUNT_W) ?
                        $clog2(STACK_PAGES_MAX + 1) : SCOUNT_W;

    logic [PAGE_W-1:0] page;
    logic [NW-1:0]     n_raw;
    logic [NW-1:0]     n_eff;
    logic [PAGE_W-1:0] n_page;
    logic [PAGE_W-1:0] srel;
    logic [PAGE_W-1:0] srel_fold;
    logic [PAGE_W-1:0] drel;
    logic              is_stack;
    logic              fold;
    logic              s_oor;
    logic              d_in;
    logic [PAGE_W-1:0] pn_stack;

    assign page  = i_item.write_addr[PAGE_SHIFT +: PAGE_W];
    assign n_raw = NW'(i_stack_count);

    // Clamp the stack page count into 1..STACK_PAGES_MAX
    always_comb begin
        if (n_raw == '0) begin
            n_eff = NW'(1);
        end else if (n_raw > NW'(STACK_PAGES_MAX)) begin
            n_eff = NW'(STACK_PAGES_MAX);
        end else begin
            n_eff = n_raw;
        end
    end

    assign n_page    = PAGE_W'(n_eff);
    assign is_stack  = i_stack_en && (page >= i_stack_base);
    assign srel      = page - i_stack_base;
    assign fold      = srel >= n_page;
    // Beyond the mirror once folded means at or above twice the count
    assign s_oor     = {1'b0, srel} >= ({1'b0, n_page} << 1);
    assign srel_fold = fold ? (srel - n_page) : srel;
    assign pn_stack  = fold ? (page - n_page) : page;
    assign o_sidx    = srel_fold[SIDX_W-1:0];

    assign drel   = page - i_data_base;
    assign d_in   = (page >= i_data_base) && (drel < PAGE_W'(DATA_PAGES));
    assign o_didx = drel[DIDX_W-1:0];

    always_comb begin
        o_item = '0;
        if (i_item.mode == MODE_TICK) begin
            o_item.status = ST_ARMED;
        end else if (!i_armed) begin
            o_item.status = ST_IGNORED;
        end else if (is_stack) begin
            o_item.region      = REGION_STACK;
            o_item.page_number = pn_stack;
            o_item.status      = s_oor ? ST_RANGE : ST_COUNTED;
        end else begin
            o_item.region      = REGION_DATA;
            o_item.page_number = page;
            o_item.status      = d_in ? ST_COUNTED : ST_RANGE;
        end
    end

endmodule

// ----- rtl/core/spwc_bump.sv -----
// Counter update: saturating increment, threshold compare and clear on hit.
// Depends on spwc_pkg.
module spwc_bump import spwc_pkg::*; (
    input  logic [CNT_W-1:0] i_count,
    input  logic [CNT_W-1:0] i_threshold,
    output logic [CNT_W-1:0] o_next,
    output logic             o_hit
);

    logic [CNT_W-1:0] cnt_inc;

    assign cnt_inc = (i_count == '1) ? i_count : (i_count + CNT_W'(1));
    assign o_hit   = cnt_inc >= i_threshold;
    assign o_next  = o_hit ? '0 : cnt_inc;

endmodule

// ----- rtl/core/sampled_page_write_counter_unit.sv -----
// Sampled page write counter: wear monitor for writes to non-volatile memory.
// Uses spwc_pkg, spwc_decode, spwc_bump and two spwc_ram count tables.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): a tick transaction
//   (mode 0) arms the monitor; the first write transaction (mode 1) after it
//   disarms it and counts its 4 KiB page in the data or stack count table.
//   Output channel (o_out_valid / i_out_ready / o_out_data): exactly one
//   result per input transaction, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready): writes
//   register i_cfg_index with i_cfg_data; write it only while idle.
// Flow: an item first reads its counter from the count memory, then is updated
//   and written back; the next item is accepted only once the previous one has
//   left the update stage. The result is registered in the output register as
//   the item leaves the update stage, and waits there for the receiver.
// Reset: registers take their reset values, the monitor is disarmed, and a
//   clearing pass over max(DATA_PAGES, STACK_PAGES_MAX) table addresses zeroes
//   both count tables; o_in_ready stays low meanwhile.
// Stall: the result waits in the output register; one more item is accepted
//   and held in the update stage, then o_in_ready drops until space frees.
module sampled_page_write_counter_unit import spwc_pkg::*; #(
    parameter int DATA_PAGES      = 1024,
    parameter int STACK_PAGES_MAX = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DIDX_W    = (DATA_PAGES > 1) ? $clog2(DATA_PAGES) : 1;
    localparam int SIDX_W    = (STACK_PAGES_MAX > 1) ? $clog2(STACK_PAGES_MAX) : 1;
    localparam int CLR_DEPTH = (DATA_PAGES > STACK_PAGES_MAX) ? DATA_PAGES : STACK_PAGES_MAX;
    localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    // Configuration registers
    logic [CNT_W-1:0]    r_threshold;
    logic [PAGE_W-1:0]   r_data_base;
    logic [PAGE_W-1:0]   r_stack_base;
    logic [SCOUNT_W-1:0] r_stack_count;
    logic                r_stack_en;

    // Control and pipeline registers
    logic              r_armed,     n_armed;
    logic              r_clr_busy;
    logic [CLR_W-1:0]  r_clr_idx;
    logic              r_s1_valid;
    t_out_item         r_s1_item;
    logic [DIDX_W-1:0] r_s1_didx;
    logic [SIDX_W-1:0] r_s1_sidx;
    logic              r_out_valid;
    t_out_item         r_out_item;

    t_out_item         dec_item;
    logic [DIDX_W-1:0] dec_didx;
    logic [SIDX_W-1:0] dec_sidx;
    logic              in_acc;
    logic              s1_adv;
    logic              s1_count;
    t_out_item         s1_result;
    logic              clr_data;
    logic              clr_stack;
    logic [CNT_W-1:0]  d_rdata;
    logic [CNT_W-1:0]  s_rdata;
    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  bump_next;
    logic              bump_hit;
    logic              d_we;
    logic              s_we;
    logic [DIDX_W-1:0] d_waddr;
    logic [SIDX_W-1:0] s_waddr;
    logic [CNT_W-1:0]  wdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_s1_valid && !r_clr_busy;
    assign in_acc      = i_in_valid && o_in_ready;
    assign s1_adv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign s1_count    = r_s1_item.status == ST_COUNTED;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESHOLD_RST;
            r_data_base   <= '0;
            r_stack_base  <= '0;
            r_stack_count <= STACK_COUNT_RST;
            r_stack_en    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[CNT_W-1:0];
                CFG_DATA_BASE:   r_data_base   <= i_cfg_data[PAGE_W-1:0];
                CFG_STACK_BASE:  r_stack_base  <= i_cfg_data[PAGE_W-1:0];
                CFG_STACK_COUNT: r_stack_count <= i_cfg_data[SCOUNT_W-1:0];
                CFG_STACK_EN:    r_stack_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    spwc_decode #(
        .DATA_PAGES      (DATA_PAGES),
        .STACK_PAGES_MAX (STACK_PAGES_MAX)
    ) u_decode (
        .i_item        (i_in_data),
        .i_armed       (r_armed),
        .i_data_base   (r_data_base),
        .i_stack_base  (r_stack_base),
        .i_stack_count (r_stack_count),
        .i_stack_en    (r_stack_en),
        .o_item        (dec_item),
        .o_didx        (dec_didx),
        .o_sidx        (dec_sidx)
    );

    // Ticks arm; any write, counted or not, disarms once armed
    assign n_armed = (i_in_data.mode == MODE_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_armed <= n_armed;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + CLR_W'(1);
                if (r_clr_idx == CLR_W'(CLR_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        s1_result           = r_s1_item;
        s1_result.rebalance = s1_count && bump_hit;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= dec_item;
            r_s1_didx <= dec_didx;
            r_s1_sidx <= dec_sidx;
        end
        if (s1_adv) begin
            r_out_item <= s1_result;
        end
    end

    // Counter memories: read on accept, write back when the result moves out
    assign clr_data  = {1'b0, r_clr_idx} < (CLR_W + 1)'(DATA_PAGES);
    assign clr_stack = {1'b0, r_clr_idx} < (CLR_W + 1)'(STACK_PAGES_MAX);

    assign d_we    = r_clr_busy ? clr_data :
                     (s1_adv && s1_count && (r_s1_item.region == REGION_DATA));
    assign s_we    = r_clr_busy ? clr_stack :
                     (s1_adv && s1_count && (r_s1_item.region == REGION_STACK));
    assign d_waddr = r_clr_busy ? r_clr_idx[DIDX_W-1:0] : r_s1_didx;
    assign s_waddr = r_clr_busy ? r_clr_idx[SIDX_W-1:0] : r_s1_sidx;
    assign wdata   = r_clr_busy ? '0 : bump_next;

    spwc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DATA_PAGES)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (wdata),
        .i_re    (in_acc && (dec_item.status == ST_COUNTED) &&
                  (dec_item.region == REGION_DATA)),
        .i_raddr (dec_didx),
        .o_rdata (d_rdata)
    );

    spwc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (STACK_PAGES_MAX)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (wdata),
        .i_re    (in_acc && (dec_item.status == ST_COUNTED) &&
                  (dec_item.region == REGION_STACK)),
        .i_raddr (dec_sidx),
        .o_rdata (s_rdata)
    );

    assign cur_count = (r_s1_item.region == REGION_STACK) ? s_rdata : d_rdata;

    spwc_bump u_bump (
        .i_count     (cur_count),
        .i_threshold (r_threshold),
        .o_next      (bump_next),
        .o_hit       (bump_hit)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

// ----- rtl/core/spwc_checker.sv -----
// Port-level checker for the sampled page write counter, bound to the top level.
// Depends on spwc_pkg.
module spwc_checker import spwc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A rebalance request only comes from a counted write
    a_rebalance_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rebalance |-> o_out_data.status == ST_COUNTED)
        else $error("rebalance on a result that was not counted");

    // Ticks and ignored writes carry no page and no region
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_ARMED || o_out_data.status == ST_IGNORED)
        |-> o_out_data.page_number == '0 && o_out_data.region == REGION_DATA)
        else $error("tick or ignored result carries page or region");

    // Check that reset holds input off, as the clearing pass of the count tables starts
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready during clearing pass");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

endmodule

bind sampled_page_write_counter_unit spwc_checker u_spwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- test/tb_sampled_page_write_counter_unit.sv -----
// Self-checking testbench for sampled_page_write_counter_unit.
// Holds a wear-count predictor, a directed stimulus list and randomized config phases.
// Depends on spwc_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_sampled_page_write_counter_unit;
    import spwc_pkg::*;

    localparam int DATA_PAGES   = 1024;
    localparam int STACK_PAGES  = 64;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_ITEMS  = 150;
    localparam int LONG_HOLD    = 300;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [PAGE_W-1:0] MAX_PAGE = {PAGE_W{1'b1}};
    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

    typedef struct packed {
        logic                  cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_in_item              item;
        logic                  typed;
        t_out_item             want;
    } t_dir_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_data = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  o_cfg_ready;

    // Predictor copy of configuration and state
    logic [CNT_W-1:0]    notify_thr = THRESHOLD_RST;
    logic [PAGE_W-1:0]   data_base = '0;
    logic [PAGE_W-1:0]   stack_base = '0;
    logic [SCOUNT_W-1:0] stack_count = STACK_COUNT_RST;
    logic                stack_on = 1'b0;
    logic                armed_now = 1'b0;
    logic [CNT_W-1:0]    data_hits [DATA_PAGES];
    logic [CNT_W-1:0]    stack_hits [STACK_PAGES];

    t_out_item pending_results [$];
    t_dir_row  dir_rows [$];

    int  n_fail = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_rebalance = 0;
    int  n_cfg = 0;
    int  cycles = 0;
    int  rx_stall = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    sampled_page_write_counter_unit #(
        .DATA_PAGES      (DATA_PAGES),
        .STACK_PAGES_MAX (STACK_PAGES)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Effective stack size: zero counts as one, clamp at the table depth
    function automatic logic [PAGE_W-1:0] stack_limit();
        if (stack_count == '0) return PAGE_W'(1);
        if (stack_count > STACK_PAGES) return PAGE_W'(STACK_PAGES);
        return PAGE_W'(stack_count);
    endfunction

    function automatic logic [CNT_W-1:0] advance_wear_count(input logic [CNT_W-1:0] c,
                                                            output logic hit);
        logic [CNT_W-1:0] nxt;
        nxt = (c == '1) ? c : c + 1'b1;
        hit = (nxt >= notify_thr);
        return hit ? '0 : nxt;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_THRESHOLD:   notify_thr  = val[CNT_W-1:0];
            CFG_DATA_BASE:   data_base   = val[PAGE_W-1:0];
            CFG_STACK_BASE:  stack_base  = val[PAGE_W-1:0];
            CFG_STACK_COUNT: stack_count = val[SCOUNT_W-1:0];
            CFG_STACK_EN:    stack_on    = val[0];
            default: ;
        endcase
    endfunction

    function automatic t_out_item count_page_write(t_in_item it);
        t_out_item         r;
        logic [PAGE_W-1:0] pg;
        logic [PAGE_W-1:0] rel;
        logic [PAGE_W-1:0] lim;
        logic              hit;
        r = '0;
        r.region = REGION_DATA;
        pg = it.write_addr[ADDR_W-1:PAGE_SHIFT];
        if (it.mode == MODE_TICK) begin
            armed_now = 1'b1;
            r.status = ST_ARMED;
        end else if (!armed_now) begin
            r.status = ST_IGNORED;
        end else begin
            armed_now = 1'b0;
            if (stack_on && pg >= stack_base) begin
                lim = stack_limit();
                rel = pg - stack_base;
                // fold the mirror once onto the real stack pages
                if (rel >= lim) rel = rel - lim;
                r.region = REGION_STACK;
                r.page_number = stack_base + rel;
                if (rel >= lim) begin
                    r.status = ST_RANGE;
                end else begin
                    r.status = ST_COUNTED;
                    stack_hits[int'(rel)] = advance_wear_count(stack_hits[int'(rel)], hit);
                    r.rebalance = hit;
                end
            end else begin
                r.page_number = pg;
                rel = pg - data_base;
                if (pg < data_base || rel >= DATA_PAGES) begin
                    r.status = ST_RANGE;
                end else begin
                    r.status = ST_COUNTED;
                    data_hits[int'(rel)] = advance_wear_count(data_hits[int'(rel)], hit);
                    r.rebalance = hit;
                end
            end
        end
        return r;
    endfunction

    // Aim mostly at hot pages near the bases so counters reach the threshold
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [PAGE_W-1:0] pg;
        logic [31:0]       low;
        int unsigned       lim;
        lim = 32'(stack_limit());
        low = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: pg = data_base + $urandom_range(0, 3);
            3:       pg = data_base + $urandom_range(0, DATA_PAGES - 1);
            4:       pg = data_base - $urandom_range(1, 4);
            5:       pg = data_base + DATA_PAGES + $urandom_range(0, 4);
            6, 7:    pg = stack_base + $urandom_range(0, 2 * lim + 3);
            8:       pg = stack_base - 1;
            default: return rand64();
        endcase
        return {pg, low[PAGE_SHIFT-1:0]};
    endfunction

    function automatic t_dir_row typed_row(logic mode, logic [ADDR_W-1:0] addr, logic reb,
                                           logic [PAGE_W-1:0] pn, logic region,
                                           logic [1:0] st);
        t_dir_row r;
        r = '0;
        r.item.mode = mode;
        r.item.write_addr = addr;
        r.typed = 1'b1;
        r.want.rebalance = reb;
        r.want.page_number = pn;
        r.want.region = region;
        r.want.status = st;
        return r;
    endfunction

    function automatic t_dir_row item_row(logic mode, logic [ADDR_W-1:0] addr);
        t_dir_row r;
        r = '0;
        r.item.mode = mode;
        r.item.write_addr = addr;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r = '0;
        r.cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        n_fail++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic push_item(t_in_item it, logic typed, t_out_item want);
        int        gap;
        t_out_item got;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!o_in_ready);
        got = count_page_write(it);
        pending_results.push_back(typed ? want : got);
        n_items++;
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        apply_setting(idx, val);
        n_cfg++;
        @(negedge clk);
    endtask

    // Drop the input stream and wait until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic program_phase(logic [CNT_W-1:0] thr, logic [PAGE_W-1:0] db,
                                 logic [PAGE_W-1:0] sb, logic [SCOUNT_W-1:0] cnt, logic en);
        settle();
        write_cfg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_cfg(CFG_DATA_BASE, db);
        write_cfg(CFG_STACK_BASE, sb);
        write_cfg(CFG_STACK_COUNT, CFG_DATA_W'(cnt));
        write_cfg(CFG_STACK_EN, CFG_DATA_W'(en));
        cfg_valid <= 1'b0;
    endtask

    // Result checker
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            n_results++;
            if (o_out_data.rebalance) n_rebalance++;
            rx_stall = rx_quiet ? 0 : $urandom_range(0, 6);
            if (pending_results.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result: expected none, got %0h", $time, o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.rebalance !== want.rebalance)
                    note_mismatch("rebalance", 64'(want.rebalance),
                                  64'(o_out_data.rebalance));
                if (o_out_data.page_number !== want.page_number)
                    note_mismatch("page_number", 64'(want.page_number),
                                  64'(o_out_data.page_number));
                if (o_out_data.region !== want.region)
                    note_mismatch("region", 64'(want.region), 64'(o_out_data.region));
                if (o_out_data.status !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(o_out_data.status));
            end
        end
    end

    // Receiver: per-result stall, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (rx_stall > 0) begin
            out_ready <= 1'b0;
            rx_stall--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("FAIL sampled_page_write_counter_unit");
            $finish;
        end
    end

    initial begin
        t_dir_row            arm;
        t_in_item            tk;
        t_in_item            wr;
        logic [CNT_W-1:0]    thr_v;
        logic [PAGE_W-1:0]   db_v;
        logic [PAGE_W-1:0]   sb_v;
        logic [SCOUNT_W-1:0] cnt_v;
        logic                en_v;
        int                  sent;
        int unsigned         pick;

        foreach (data_hits[k]) data_hits[k] = '0;
        foreach (stack_hits[k]) stack_hits[k] = '0;

        arm = typed_row(MODE_TICK, 64'h0, 1'b0, 52'd0, REGION_DATA, ST_ARMED);
        dir_rows = '{
            typed_row(MODE_WRITE, 64'h0, 1'b0, 52'd0, REGION_DATA, ST_IGNORED),
            typed_row(MODE_TICK, ALL_ONES, 1'b0, 52'd0, REGION_DATA, ST_ARMED),
            arm,
            typed_row(MODE_WRITE, 64'h0, 1'b0, 52'd0, REGION_DATA, ST_COUNTED),
            typed_row(MODE_WRITE, ALL_ONES, 1'b0, 52'd0, REGION_DATA, ST_IGNORED),
            arm,
            typed_row(MODE_WRITE, ALL_ONES, 1'b0, MAX_PAGE, REGION_DATA, ST_RANGE),
            arm,
            typed_row(MODE_WRITE, 64'h3F_FFFF, 1'b0, 52'h3FF, REGION_DATA, ST_COUNTED),
            cfg_row(CFG_THRESHOLD, 52'd0),
            arm,
            typed_row(MODE_WRITE, 64'h5000, 1'b1, 52'h5, REGION_DATA, ST_COUNTED),
            cfg_row(CFG_DATA_BASE, 52'd100),
            cfg_row(CFG_STACK_BASE, 52'h200),
            cfg_row(CFG_STACK_COUNT, 52'd0),
            cfg_row(CFG_STACK_EN, 52'd1),
            arm,
            typed_row(MODE_WRITE, 64'h20_0000, 1'b1, 52'h200, REGION_STACK, ST_COUNTED),
            arm,
            typed_row(MODE_WRITE, 64'h20_1ABC, 1'b1, 52'h200, REGION_STACK, ST_COUNTED),
            arm,
            typed_row(MODE_WRITE, 64'h20_2000, 1'b0, 52'h201, REGION_STACK, ST_RANGE),
            arm,
            typed_row(MODE_WRITE, 64'h6_3000, 1'b0, 52'd99, REGION_DATA, ST_RANGE),
            cfg_row(CFG_STACK_COUNT, 52'd127),
            cfg_row(CFG_THRESHOLD, 52'hFFFF_FFFF),
            arm,
            item_row(MODE_WRITE, 64'h27_F000),
            arm,
            item_row(MODE_WRITE, 64'h28_0000),
            arm,
            typed_row(MODE_WRITE, 64'h6_4FFF, 1'b0, 52'd100, REGION_DATA, ST_COUNTED)
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].cfg) begin
                settle();
                write_cfg(dir_rows[k].idx, dir_rows[k].val);
                cfg_valid <= 1'b0;
            end else begin
                push_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    thr_v = '0; db_v = '0; sb_v = '0; cnt_v = 7'd64; en_v = 1'b1;
                end
                1: begin
                    thr_v = 32'd1; db_v = MAX_PAGE - 1023; sb_v = MAX_PAGE - 63;
                    cnt_v = 7'd1; en_v = 1'b1;
                end
                2: begin
                    thr_v = '1; db_v = MAX_PAGE; sb_v = '0; cnt_v = 7'd64; en_v = 1'b0;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       thr_v = '0;
                        1:       thr_v = '1;
                        2:       thr_v = $urandom;
                        default: thr_v = $urandom_range(1, 6);
                    endcase
                    db_v  = ($urandom_range(0, 3) == 0) ? '0 : PAGE_W'(rand64());
                    // put the stack base near the data region so both tables mix
                    sb_v  = db_v + $urandom_range(0, DATA_PAGES + 100);
                    cnt_v = ($urandom_range(0, 3) == 0) ?
                            SCOUNT_W'($urandom_range(0, 127)) :
                            SCOUNT_W'($urandom_range(1, STACK_PAGES));
                    en_v  = ($urandom_range(0, 3) != 0);
                end
            endcase
            program_phase(thr_v, db_v, sb_v, cnt_v, en_v);
            tx_quiet = (p % 3 == 2) || (p == 4);
            rx_quiet = (p % 3 == 2);
            // fill the unit while the receiver holds off
            if (p == 4) hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                tk = '{MODE_TICK, rand64()};
                wr = '{MODE_WRITE, pick_addr()};
                pick = $urandom_range(0, 99);
                push_item(tk, 1'b0, '0);
                if (pick < 75) begin
                    push_item(wr, 1'b0, '0);
                    sent += 2;
                end else if (pick < 85) begin
                    // stray tick with no write behind it
                    sent += 1;
                end else if (pick < 93) begin
                    push_item(tk, 1'b0, '0);
                    push_item(wr, 1'b0, '0);
                    sent += 3;
                end else begin
                    // second write lands while disarmed
                    push_item(wr, 1'b0, '0);
                    wr = '{MODE_WRITE, pick_addr()};
                    push_item(wr, 1'b0, '0);
                    sent += 3;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d transactions with %0d results, %0d rebalance requests,",
                 n_items, n_results, n_rebalance);
        $display("%0d register writes over %0d config phases.", n_cfg, NUM_PHASES + 3);
        if (n_fail == 0) begin
            $display("PASS sampled_page_write_counter_unit");
        end else begin
            $display("FAIL sampled_page_write_counter_unit");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/spwc_pkg.sv
rtl/core/spwc_ram.sv
rtl/core/spwc_decode.sv
rtl/core/spwc_bump.sv
rtl/core/sampled_page_write_counter_unit.sv
rtl/core/spwc_checker.sv
test/tb_sampled_page_write_counter_unit.sv
